>>> src/hkbt_pkg.sv
`timescale 1ns / 1ps

package hkbt_pkg;

  // table geometry
  localparam int BUCKETS         = 16;
  localparam int BUCKET_DEPTH    = 8;
  localparam int SLOTS           = BUCKETS * BUCKET_DEPTH;
  localparam int SLOT_W          = $clog2(SLOTS);
  localparam int DEPTH_W         = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int DEFAULT_BUCKETS = 4;

  // field widths
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int OPC_W   = 3;
  localparam int NB_W    = 5;
  localparam int COUNT_W = 8;
  localparam int KCNT_W  = $clog2(KEY_W);

  typedef enum logic [OPC_W-1:0] {
    OP_LOOKUP        = 3'd0,
    OP_SEARCH_INSERT = 3'd1,
    OP_UPSERT        = 3'd2,
    OP_ERASE         = 3'd3,
    OP_CLEAR         = 3'd4
  } opcode_t;

endpackage

>>> src/hkbt_ram.sv
`timescale 1ns / 1ps

module hkbt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/hkbt_mod_unit.sv
`timescale 1ns / 1ps

// bit-serial remainder of key by a small divisor, one key bit per cycle
module hkbt_mod_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [hkbt_pkg::KEY_W-1:0] key,
  input  logic [hkbt_pkg::NB_W-1:0]  divisor,
  output logic                      done,
  output logic [hkbt_pkg::NB_W-1:0]  rem
);

  import hkbt_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [KCNT_W-1:0] cnt_r;
  logic [KEY_W-1:0]  key_r;
  logic [NB_W-1:0]   div_r;
  logic [NB_W-1:0]   rem_r;
  logic [NB_W:0]     trial;
  logic [NB_W:0]     diff;

  assign trial = {rem_r, key_r[KEY_W-1]};
  assign diff  = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        key_r  <= key;
        div_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        key_r <= {key_r[KEY_W-2:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
        if (trial >= {1'b0, div_r}) begin
          rem_r <= diff[NB_W-1:0];
        end else begin
          rem_r <= trial[NB_W-1:0];
        end
        if (cnt_r == KCNT_W'(KEY_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

>>> src/hashed_key_bucket_table.sv
`timescale 1ns / 1ps

// hashed key bucket table: a hash table of 16 buckets of 8 slots each that takes
// keys already hashed to 32 bits. the bucket is the hash modulo the bucket count
// written on the cfg port (0 acts as 4, above 16 acts as 16, reset 4); inside the
// bucket an entry matches on the full 32-bit hash. opcodes in in_tuser: lookup,
// search-or-insert (absent key inserted with value 0), upsert, erase and clear;
// codes 5 to 7 change nothing. an insert into a full bucket is refused with status
// 1. each transaction returns exactly one result transaction. the block takes one
// transaction at a time: lookup, search-or-insert, upsert and erase run the bit-serial
// modulo unit, scan the 8 slots of the bucket through the registered read port of
// the tag and value rams, then do the update and go back to idle; clear and unused
// codes skip the modulo and scan steps and go straight from idle to the update step.
// a finished result sits in the output register while the next transaction is taken;
// if that result is still held off when the next one is done, the block waits in its
// update step and drops in_tready until the receiver takes the result.
// slot valid bits live in flops, so the table is empty right out of reset.
module hashed_key_bucket_table (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_wr_en,
  input  logic [hkbt_pkg::NB_W-1:0]   cfg_wr_data,   // num_buckets
  // request stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [63:0]                 in_tdata,      // key_hash[31:0], write_value[63:32]
  input  logic [hkbt_pkg::OPC_W-1:0]  in_tuser,      // opcode[2:0]
  // result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [47:0]                 out_tdata      // found[0], read_value[32:1],
                                                     // status[33], entry_total[41:34],
                                                     // zero[47:42]
);

  import hkbt_pkg::*;

  localparam int OUT_W   = 48;
  localparam int OUT_PAD = OUT_W - (1 + VAL_W + 1 + COUNT_W);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_SCAN,
    S_ACT
  } state_t;

  state_t             state_r;

  // configuration and table state
  logic [NB_W-1:0]    num_buckets_r;
  logic [NB_W-1:0]    eff_buckets;
  logic [SLOTS-1:0]   valid_r;
  logic [COUNT_W-1:0] count_r;

  // transaction held while it is worked on
  logic [OPC_W-1:0]   op_r;
  logic [KEY_W-1:0]   key_r;
  logic [VAL_W-1:0]   wval_r;

  // bucket scan
  logic [DEPTH_W:0]   rd_idx_r;
  logic               cmp_vld_r;
  logic [DEPTH_W-1:0] cmp_idx_r;
  logic               hit_vld_r;
  logic [SLOT_W-1:0]  hit_slot_r;
  logic [VAL_W-1:0]   hit_val_r;
  logic               free_vld_r;
  logic [SLOT_W-1:0]  free_slot_r;

  logic [SLOT_W-1:0]  base;
  logic [SLOT_W-1:0]  scan_slot;
  logic [SLOT_W-1:0]  cmp_slot;
  logic [KEY_W-1:0]   tag_rdata;
  logic [VAL_W-1:0]   val_rdata;

  // modulo unit
  logic               mod_start;
  logic               mod_done;
  logic [NB_W-1:0]    mod_rem;

  // output register
  logic               out_tvalid_r;
  logic               out_found_r;
  logic [VAL_W-1:0]   out_rval_r;
  logic               out_status_r;
  logic [COUNT_W-1:0] out_total_r;
  logic               out_free;

  // update decision
  logic               act_go;
  logic               act_found;
  logic [VAL_W-1:0]   act_rval;
  logic               act_status;
  logic [COUNT_W-1:0] count_nxt;
  logic               tag_we;
  logic               val_we;
  logic [SLOT_W-1:0]  wr_slot;
  logic [VAL_W-1:0]   wr_val;
  logic               set_valid;
  logic               clr_valid;
  logic               clr_all;

  // zero means default, anything past the table saturates
  always_comb begin
    if (num_buckets_r == '0) begin
      eff_buckets = NB_W'(DEFAULT_BUCKETS);
    end else if (num_buckets_r > NB_W'(BUCKETS)) begin
      eff_buckets = NB_W'(BUCKETS);
    end else begin
      eff_buckets = num_buckets_r;
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign mod_start = (state_r == S_IDLE) && in_tvalid && (in_tuser <= OP_ERASE);

  hkbt_mod_unit u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mod_start),
    .key     (in_tdata[KEY_W-1:0]),
    .divisor (eff_buckets),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  // bucket b owns slots b*BUCKET_DEPTH and up
  assign base      = SLOT_W'(mod_rem) * SLOT_W'(BUCKET_DEPTH);
  assign scan_slot = base + SLOT_W'(rd_idx_r[DEPTH_W-1:0]);
  assign cmp_slot  = base + SLOT_W'(cmp_idx_r);

  hkbt_ram #(
    .WIDTH (KEY_W),
    .DEPTH (SLOTS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (wr_slot),
    .wdata (key_r),
    .raddr (scan_slot),
    .rdata (tag_rdata)
  );

  hkbt_ram #(
    .WIDTH (VAL_W),
    .DEPTH (SLOTS)
  ) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (wr_slot),
    .wdata (wr_val),
    .raddr (scan_slot),
    .rdata (val_rdata)
  );

  assign out_free = !out_tvalid_r || out_tready;
  assign act_go   = (state_r == S_ACT) && out_free;

  // outcome of the operation once the bucket has been scanned
  always_comb begin
    act_found  = 1'b0;
    act_rval   = '0;
    act_status = 1'b0;
    count_nxt  = count_r;
    tag_we     = 1'b0;
    val_we     = 1'b0;
    wr_slot    = hit_slot_r;
    wr_val     = wval_r;
    set_valid  = 1'b0;
    clr_valid  = 1'b0;
    clr_all    = 1'b0;
    case (op_r)
      OP_LOOKUP: begin
        if (hit_vld_r) begin
          act_found = 1'b1;
          act_rval  = hit_val_r;
        end
      end
      OP_SEARCH_INSERT: begin
        if (hit_vld_r) begin
          act_found = 1'b1;
          act_rval  = hit_val_r;
        end else if (free_vld_r) begin
          tag_we    = act_go;
          val_we    = act_go;
          wr_slot   = free_slot_r;
          wr_val    = '0;
          set_valid = 1'b1;
          count_nxt = count_r + 1'b1;
        end else begin
          act_status = 1'b1;
        end
      end
      OP_UPSERT: begin
        if (hit_vld_r) begin
          act_found = 1'b1;
          act_rval  = wval_r;
          val_we    = act_go;
        end else if (free_vld_r) begin
          act_rval  = wval_r;
          tag_we    = act_go;
          val_we    = act_go;
          wr_slot   = free_slot_r;
          set_valid = 1'b1;
          count_nxt = count_r + 1'b1;
        end else begin
          act_status = 1'b1;
        end
      end
      OP_ERASE: begin
        if (hit_vld_r) begin
          act_found = 1'b1;
          clr_valid = 1'b1;
          if (count_r != '0) begin
            count_nxt = count_r - 1'b1;
          end
        end
      end
      OP_CLEAR: begin
        clr_all   = 1'b1;
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      num_buckets_r <= NB_W'(DEFAULT_BUCKETS);
      valid_r       <= '0;
      count_r       <= '0;
      out_tvalid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        num_buckets_r <= cfg_wr_data;
      end
      // a new result may replace the one leaving in the same cycle
      if (act_go) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r       <= in_tuser;
            key_r      <= in_tdata[KEY_W-1:0];
            wval_r     <= in_tdata[KEY_W+VAL_W-1:KEY_W];
            rd_idx_r   <= '0;
            cmp_vld_r  <= 1'b0;
            hit_vld_r  <= 1'b0;
            free_vld_r <= 1'b0;
            // clear and unused codes need no bucket
            state_r    <= (in_tuser <= OP_ERASE) ? S_DIV : S_ACT;
          end
        end
        S_DIV: begin
          if (mod_done) begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          // issue one slot read per cycle, compare its data in the cycle after the read
          if (rd_idx_r < (DEPTH_W+1)'(BUCKET_DEPTH)) begin
            rd_idx_r  <= rd_idx_r + 1'b1;
            cmp_vld_r <= 1'b1;
            cmp_idx_r <= rd_idx_r[DEPTH_W-1:0];
          end else begin
            cmp_vld_r <= 1'b0;
          end
          if (cmp_vld_r) begin
            if (valid_r[cmp_slot]) begin
              if (!hit_vld_r && (tag_rdata == key_r)) begin
                hit_vld_r  <= 1'b1;
                hit_slot_r <= cmp_slot;
                hit_val_r  <= val_rdata;
              end
            end else if (!free_vld_r) begin
              free_vld_r  <= 1'b1;
              free_slot_r <= cmp_slot;
            end
          end
          if ((rd_idx_r == (DEPTH_W+1)'(BUCKET_DEPTH)) && !cmp_vld_r) begin
            state_r <= S_ACT;
          end
        end
        S_ACT: begin
          // wait here until the output register can take the result
          if (out_free) begin
            if (clr_all) begin
              valid_r <= '0;
            end else if (set_valid) begin
              valid_r[free_slot_r] <= 1'b1;
            end else if (clr_valid) begin
              valid_r[hit_slot_r] <= 1'b0;
            end
            count_r      <= count_nxt;
            out_found_r  <= act_found;
            out_rval_r   <= act_rval;
            out_status_r <= act_status;
            out_total_r  <= count_nxt;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {OUT_PAD'(0), out_total_r, out_status_r, out_rval_r, out_found_r};

`ifndef ASSERT_OFF
  // running count tracks the number of occupied slots
  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(count_r))
    else $error("entry count disagrees with valid slots");

  // scan index never runs past the bucket
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rd_idx_r <= (DEPTH_W+1)'(BUCKET_DEPTH) || state_r != S_SCAN)
    else $error("bucket scan ran past the bucket");

  // a result only appears out of the update step
  a_result_from_act: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == S_ACT))
    else $error("result raised outside the update step");

  // the modulo unit only finishes while the sequencer waits for it
  a_mod_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> state_r == S_DIV)
    else $error("modulo result arrived outside the divide step");
`endif

endmodule
